@@ rtl/kadc_pkg.sv @@
// shared types, constants and helpers of the keypad arm/disarm controller
// no dependencies; imported by every module of the block
package kadc_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 8;

  localparam int unsigned NUM_REGS   = 5;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;

  localparam logic [2:0] REG_ARM_CODE    = 3'd0;
  localparam logic [2:0] REG_DISARM_CODE = 3'd1;
  localparam logic [2:0] REG_COUNTDOWN   = 3'd2;
  localparam logic [2:0] REG_SECOND_LIM  = 3'd3;
  localparam logic [2:0] REG_BLINK_LIM   = 3'd4;

  localparam logic [5:0]  ARM_CODE_RST    = 6'd57;
  localparam logic [5:0]  DISARM_CODE_RST = 6'd27;
  localparam logic [3:0]  COUNTDOWN_RST   = 4'd10;
  localparam logic [10:0] SECOND_LIM_RST  = 11'd1000;
  localparam logic [10:0] BLINK_LIM_RST   = 11'd255;

  localparam logic [1:0] BUTTON_NONE = 2'd0;
  localparam logic [1:0] BUTTON_1    = 2'd1;
  localparam logic [1:0] BUTTON_2    = 2'd2;
  localparam logic [1:0] BUTTON_3    = 2'd3;

  localparam logic [1:0] ENTRY_FULL  = 2'd3;

  typedef enum logic [1:0] {
    NOTIFY_NONE    = 2'd0,
    NOTIFY_RAISED  = 2'd1,
    NOTIFY_CLEARED = 2'd2
  } notify_t;

  typedef struct packed {
    logic [5:0]  arm_code;
    logic [5:0]  disarm_code;
    logic [3:0]  countdown_seconds;
    logic [10:0] second_limit;
    logic [10:0] blink_limit;
  } cfg_regs_t;

  // countdown length write, used to reload the idle countdown
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } cfg_reload_t;

  typedef struct packed {
    logic       is_armed;
    logic       alarm_out;
    logic       led_a;
    logic       led_b;
    logic       motor_start;
    logic       motor_reverse;
    logic [1:0] entry_count;
    logic [3:0] seconds_shown;
    notify_t    notify;
    logic [2:0] clean_buttons;
  } result_t;

  function automatic logic [1:0] code_digit(input logic [5:0] code, input logic [1:0] pos);
    logic [1:0] d;
    unique case (pos)
      2'd0:    d = code[1:0];
      2'd1:    d = code[3:2];
      2'd2:    d = code[5:4];
      default: d = BUTTON_NONE;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/kadc_cfg.sv @@
// configuration register file with apb-style access
// depends on kadc_pkg
module kadc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kadc_pkg::ADDR_W-1:0]   paddr,
  input  logic [kadc_pkg::DATA_W-1:0]   pwdata,
  output logic [kadc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output kadc_pkg::cfg_regs_t           regs,
  output kadc_pkg::cfg_reload_t         reload
);
  import kadc_pkg::*;

  cfg_regs_t  regs_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.arm_code          <= ARM_CODE_RST;
      regs_r.disarm_code       <= DISARM_CODE_RST;
      regs_r.countdown_seconds <= COUNTDOWN_RST;
      regs_r.second_limit      <= SECOND_LIM_RST;
      regs_r.blink_limit       <= BLINK_LIM_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ARM_CODE:    regs_r.arm_code          <= pwdata[5:0];
        REG_DISARM_CODE: regs_r.disarm_code       <= pwdata[5:0];
        REG_COUNTDOWN:   regs_r.countdown_seconds <= pwdata[3:0];
        REG_SECOND_LIM:  regs_r.second_limit      <= pwdata[10:0];
        REG_BLINK_LIM:   regs_r.blink_limit       <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  assign reload.valid = wr_en && (idx == REG_COUNTDOWN);
  assign reload.value = pwdata[3:0];
  assign regs         = regs_r;

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ARM_CODE:    prdata[5:0]  = regs_r.arm_code;
      REG_DISARM_CODE: prdata[5:0]  = regs_r.disarm_code;
      REG_COUNTDOWN:   prdata[3:0]  = regs_r.countdown_seconds;
      REG_SECOND_LIM:  prdata[10:0] = regs_r.second_limit;
      REG_BLINK_LIM:   prdata[10:0] = regs_r.blink_limit;
      default:         prdata       = '0;
    endcase
  end

endmodule

@@ rtl/kadc_debounce.sv @@
// button debouncer: sample shift line and debounced levels
// depends on kadc_pkg
module kadc_debounce #(
  parameter int unsigned HISTORY_DEPTH = kadc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [2:0] raw,
  output logic [2:0] falling,
  output logic [2:0] stable_nxt
);
  import kadc_pkg::*;

  logic [2:0] hist_r [HISTORY_DEPTH-1];
  logic [2:0] stable_r;
  logic [2:0] all_high;
  logic [2:0] any_high;

  // the stored samples and the new one make up the full history
  always_comb begin
    all_high = raw;
    any_high = raw;
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      all_high = all_high & hist_r[i];
      any_high = any_high | hist_r[i];
    end
  end

  assign falling    = stable_r & ~any_high;
  assign stable_nxt = all_high | (stable_r & any_high);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_r[i] <= '0;
      end
      stable_r <= '0;
    end else if (step_en) begin
      hist_r[0] <= raw;
      for (int i = 1; i < HISTORY_DEPTH - 1; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      stable_r <= stable_nxt;
    end
  end

endmodule

@@ rtl/kadc_core.sv @@
// code entry, countdown, arm state and alarm blink for one tick
// depends on kadc_pkg
module kadc_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic [2:0]             raw,
  input  logic [2:0]             falling,
  input  logic [2:0]             stable_nxt,
  input  kadc_pkg::cfg_regs_t    regs,
  input  kadc_pkg::cfg_reload_t  reload,
  output kadc_pkg::result_t      result
);
  import kadc_pkg::*;

  logic [1:0]  last_button_r, last_button_nxt;
  logic [1:0]  entry_pos_r,   entry_pos_nxt;
  logic        armed_r,       armed_nxt;
  logic        counting_r,    counting_nxt;
  logic [3:0]  seconds_r,     seconds_nxt;
  logic [10:0] tick_r,        tick_nxt;
  logic        alarm_r,       alarm_nxt;
  logic        led_a_r,       led_a_nxt;
  logic        led_b_r,       led_b_nxt;

  logic        motor_start;
  logic        motor_reverse;
  notify_t     notify;
  logic [11:0] tick_inc;
  logic [1:0]  digit;

  always_comb begin
    last_button_nxt = last_button_r;
    entry_pos_nxt   = entry_pos_r;
    armed_nxt       = armed_r;
    counting_nxt    = counting_r;
    seconds_nxt     = seconds_r;
    tick_nxt        = tick_r;
    alarm_nxt       = alarm_r;
    led_a_nxt       = led_a_r;
    led_b_nxt       = led_b_r;
    motor_start     = 1'b0;
    motor_reverse   = 1'b0;
    notify          = NOTIFY_NONE;
    tick_inc        = '0;
    digit           = last_button_r;

    if (falling != 3'b000) begin
      // lowest raw pressed button wins; none pressed keeps the last digit
      priority if (!raw[0]) digit = BUTTON_1;
      else if (!raw[1])     digit = BUTTON_2;
      else if (!raw[2])     digit = BUTTON_3;
      else                  digit = last_button_r;
      last_button_nxt = digit;

      if (entry_pos_r != ENTRY_FULL && !armed_r &&
          code_digit(regs.arm_code, entry_pos_r) == digit) begin
        entry_pos_nxt = entry_pos_r + 2'd1;
        if (entry_pos_nxt == ENTRY_FULL) begin
          counting_nxt = 1'b1;
        end
      end else if (entry_pos_r != ENTRY_FULL && armed_r &&
                   code_digit(regs.disarm_code, entry_pos_r) == digit) begin
        entry_pos_nxt = entry_pos_r + 2'd1;
        if (entry_pos_nxt == ENTRY_FULL) begin
          // alarm stop forces led a to 0; the arm change toggles led b
          alarm_nxt       = 1'b0;
          notify          = NOTIFY_CLEARED;
          motor_start     = 1'b1;
          motor_reverse   = 1'b1;
          led_a_nxt       = 1'b0;
          led_b_nxt       = ~led_b_r;
          armed_nxt       = 1'b0;
          entry_pos_nxt   = '0;
          last_button_nxt = BUTTON_NONE;
        end
      end else begin
        if (armed_r) begin
          alarm_nxt = 1'b1;
          notify    = NOTIFY_RAISED;
        end
        entry_pos_nxt   = '0;
        last_button_nxt = BUTTON_NONE;
      end
    end

    if (counting_nxt) begin
      tick_inc = {1'b0, tick_nxt} + 12'd1;
      if (tick_inc > {1'b0, regs.second_limit}) begin
        tick_nxt = '0;
        if (seconds_nxt <= 4'd1) begin
          counting_nxt    = 1'b0;
          seconds_nxt     = regs.countdown_seconds;
          motor_start     = 1'b1;
          motor_reverse   = armed_nxt;
          led_a_nxt       = ~led_a_nxt;
          led_b_nxt       = ~led_b_nxt;
          armed_nxt       = ~armed_nxt;
          entry_pos_nxt   = '0;
          last_button_nxt = BUTTON_NONE;
        end else begin
          seconds_nxt = seconds_nxt - 4'd1;
        end
      end else begin
        tick_nxt = tick_inc[10:0];
      end
    end

    // blink shares the tick counter with the countdown
    if (alarm_nxt) begin
      tick_inc = {1'b0, tick_nxt} + 12'd1;
      if (tick_inc > {1'b0, regs.blink_limit}) begin
        tick_nxt  = '0;
        led_a_nxt = ~led_a_nxt;
      end else begin
        tick_nxt = tick_inc[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_button_r <= BUTTON_NONE;
      entry_pos_r   <= '0;
      armed_r       <= 1'b0;
      counting_r    <= 1'b0;
      seconds_r     <= COUNTDOWN_RST;
      tick_r        <= '0;
      alarm_r       <= 1'b0;
      led_a_r       <= 1'b0;
      led_b_r       <= 1'b1;
    end else if (step_en) begin
      last_button_r <= last_button_nxt;
      entry_pos_r   <= entry_pos_nxt;
      armed_r       <= armed_nxt;
      counting_r    <= counting_nxt;
      seconds_r     <= seconds_nxt;
      tick_r        <= tick_nxt;
      alarm_r       <= alarm_nxt;
      led_a_r       <= led_a_nxt;
      led_b_r       <= led_b_nxt;
    end else if (reload.valid && !counting_r) begin
      seconds_r <= reload.value;
    end
  end

  assign result.is_armed      = armed_nxt;
  assign result.alarm_out     = alarm_nxt;
  assign result.led_a         = led_a_nxt;
  assign result.led_b         = led_b_nxt;
  assign result.motor_start   = motor_start;
  assign result.motor_reverse = motor_start & motor_reverse;
  assign result.entry_count   = entry_pos_nxt;
  assign result.seconds_shown = counting_nxt ? seconds_nxt : 4'd0;
  assign result.notify        = notify;
  assign result.clean_buttons = stable_nxt;

endmodule

@@ rtl/keypad_arm_disarm_controller.sv @@
// Keypad arm/disarm controller, top level.
// Input channel: one beat per 1 ms tick, in_buttons_n holds the raw
// active-low levels of three buttons (bit 0 is button 1).
// Result channel: one beat per input beat with arm state, alarm, both LEDs,
// a motor turn request and direction, digits entered, countdown seconds,
// a notify code and the debounced button levels.
// Configuration: apb-style registers at 4*i: arm code, disarm code,
// countdown seconds, second limit and blink limit; pready is always high.
// A beat accepted into the input register is presented on out_valid from
// the result register. Throughput: one beat per cycle unless out_stall
// holds a result; the tick is one pass of logic between the input register
// and the result register, with history and control state updated in the same edge.
// Reset (rst_n low, synchronous) clears the debounce history, so all
// buttons start debounced as pressed, loads the register defaults and
// leaves the block disarmed; no clearing pass is needed.
// When out_stall holds a result, one more beat is taken into the input
// register; in_stall rises only when that register is also full.
module keypad_arm_disarm_controller #(
  parameter int unsigned HISTORY_DEPTH = kadc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_buttons_n,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_armed,
  output logic                          out_alarm_out,
  output logic                          out_led_a,
  output logic                          out_led_b,
  output logic                          out_motor_start,
  output logic                          out_motor_reverse,
  output logic [1:0]                    out_entry_count,
  output logic [3:0]                    out_seconds_shown,
  output logic [1:0]                    out_notify,
  output logic [2:0]                    out_clean_buttons,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kadc_pkg::ADDR_W-1:0]   paddr,
  input  logic [kadc_pkg::DATA_W-1:0]   pwdata,
  output logic [kadc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import kadc_pkg::*;

  logic        s1_valid_r;
  logic [2:0]  s1_buttons_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res_nxt;
  logic        step_en;
  logic [2:0]  falling;
  logic [2:0]  stable_nxt;
  cfg_regs_t   regs;
  cfg_reload_t reload;

  assign step_en  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & out_valid_r & out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_buttons_r <= in_buttons_n;
    end
  end

  kadc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs),
    .reload  (reload)
  );

  kadc_debounce #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .raw        (s1_buttons_r),
    .falling    (falling),
    .stable_nxt (stable_nxt)
  );

  kadc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .raw        (s1_buttons_r),
    .falling    (falling),
    .stable_nxt (stable_nxt),
    .regs       (regs),
    .reload     (reload),
    .result     (res_nxt)
  );

  // result register, the output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_armed      = res_r.is_armed;
  assign out_alarm_out     = res_r.alarm_out;
  assign out_led_a         = res_r.led_a;
  assign out_led_b         = res_r.led_b;
  assign out_motor_start   = res_r.motor_start;
  assign out_motor_reverse = res_r.motor_reverse;
  assign out_entry_count   = res_r.entry_count;
  assign out_seconds_shown = res_r.seconds_shown;
  assign out_notify        = res_r.notify;
  assign out_clean_buttons = res_r.clean_buttons;

endmodule

@@ bench/tb_top.sv @@
// testbench of the keypad arm/disarm controller: drives button ticks and apb register
// writes, mirrors the debounce, code entry, countdown and alarm logic and checks every beat
// depends on rtl/kadc_pkg.sv and rtl/keypad_arm_disarm_controller.sv
`timescale 1ns / 100ps

module tb_top;
  import kadc_pkg::*;

  localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          in_buttons_n = 3'b111;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_is_armed;
  logic                out_alarm_out;
  logic                out_led_a;
  logic                out_led_b;
  logic                out_motor_start;
  logic                out_motor_reverse;
  logic [1:0]          out_entry_count;
  logic [3:0]          out_seconds_shown;
  logic [1:0]          out_notify;
  logic [2:0]          out_clean_buttons;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  keypad_arm_disarm_controller u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_buttons_n      (in_buttons_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_armed      (out_is_armed),
    .out_alarm_out     (out_alarm_out),
    .out_led_a         (out_led_a),
    .out_led_b         (out_led_b),
    .out_motor_start   (out_motor_start),
    .out_motor_reverse (out_motor_reverse),
    .out_entry_count   (out_entry_count),
    .out_seconds_shown (out_seconds_shown),
    .out_notify        (out_notify),
    .out_clean_buttons (out_clean_buttons),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // register mirror
  logic [5:0]  reg_arm = ARM_CODE_RST;
  logic [5:0]  reg_disarm = DISARM_CODE_RST;
  logic [3:0]  reg_cd = COUNTDOWN_RST;
  logic [10:0] reg_sec_lim = SECOND_LIM_RST;
  logic [10:0] reg_blink_lim = BLINK_LIM_RST;

  // lock state mirror
  logic [2:0]  db_hist [HIST_DEPTH];
  int          db_slot = 0;
  logic [2:0]  db_level = 3'b000;
  logic [1:0]  key_last = BUTTON_NONE;
  logic [1:0]  key_pos = 2'd0;
  logic        lock_armed = 1'b0;
  logic        cd_run = 1'b0;
  logic [3:0]  cd_secs = COUNTDOWN_RST;
  logic [10:0] shared_ticks = '0;
  logic        siren_on = 1'b0;
  logic        led_a_q = 1'b0;
  logic        led_b_q = 1'b1;

  result_t     status_q [$];

  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_arm_turns = 0;
  int n_disarm_turns = 0;
  int n_alarms = 0;

  initial forever #4 clk = ~clk;

  function automatic logic [1:0] code_at(input logic [5:0] code, input logic [1:0] pos);
    logic [5:0] sh;
    sh = code >> (2 * pos);
    return sh[1:0];
  endfunction

  // one shared tick counter serves both the countdown second and the blink period
  function automatic logic tick_wrap(input logic [10:0] lim);
    logic [11:0] nxt;
    nxt = {1'b0, shared_ticks} + 12'd1;
    if (nxt > {1'b0, lim}) begin
      shared_ticks = '0;
      return 1'b1;
    end
    shared_ticks = nxt[10:0];
    return 1'b0;
  endfunction

  function automatic result_t next_lock_status(input logic [2:0] raw);
    result_t r;
    logic [2:0] all_hi;
    logic [2:0] any_hi;
    logic [2:0] fall;
    logic turn;
    logic rev;
    notify_t note;
    int i;
    db_hist[db_slot] = raw;
    all_hi = 3'b111;
    any_hi = 3'b000;
    for (i = 0; i < HIST_DEPTH; i++) begin
      all_hi &= db_hist[i];
      any_hi |= db_hist[i];
    end
    fall = db_level & ~any_hi;
    db_level = all_hi | (db_level & any_hi);
    db_slot = (db_slot + 1 >= HIST_DEPTH) ? 0 : db_slot + 1;
    turn = 1'b0;
    rev = 1'b0;
    note = NOTIFY_NONE;

    if (fall != 3'b000) begin
      // lowest pressed button wins; none pressed keeps the previous digit
      if (!raw[0]) key_last = BUTTON_1;
      else if (!raw[1]) key_last = BUTTON_2;
      else if (!raw[2]) key_last = BUTTON_3;

      if (key_pos != ENTRY_FULL && !lock_armed && code_at(reg_arm, key_pos) == key_last) begin
        key_pos = key_pos + 2'd1;
        if (key_pos == ENTRY_FULL) cd_run = 1'b1;
      end else if (key_pos != ENTRY_FULL && lock_armed &&
                   code_at(reg_disarm, key_pos) == key_last) begin
        key_pos = key_pos + 2'd1;
        if (key_pos == ENTRY_FULL) begin
          siren_on = 1'b0;
          note = NOTIFY_CLEARED;
          turn = 1'b1;
          rev = lock_armed;
          led_a_q = 1'b0;  // forced off by the alarm stop
          led_b_q = ~led_b_q;
          lock_armed = ~lock_armed;
          key_pos = 2'd0;
          key_last = BUTTON_NONE;
        end
      end else begin
        if (lock_armed) begin
          siren_on = 1'b1;
          note = NOTIFY_RAISED;
        end
        key_pos = 2'd0;
        key_last = BUTTON_NONE;
      end
    end

    if (cd_run) begin
      if (tick_wrap(reg_sec_lim)) begin
        if (cd_secs <= 4'd1) begin
          cd_run = 1'b0;
          cd_secs = reg_cd;
          turn = 1'b1;
          rev = lock_armed;
          led_a_q = ~led_a_q;
          led_b_q = ~led_b_q;
          lock_armed = ~lock_armed;
          key_pos = 2'd0;
          key_last = BUTTON_NONE;
        end else begin
          cd_secs = cd_secs - 4'd1;
        end
      end
    end

    if (siren_on) begin
      if (tick_wrap(reg_blink_lim)) led_a_q = ~led_a_q;
    end

    r.is_armed      = lock_armed;
    r.alarm_out     = siren_on;
    r.led_a         = led_a_q;
    r.led_b         = led_b_q;
    r.motor_start   = turn;
    r.motor_reverse = turn & rev;
    r.entry_count   = key_pos;
    r.seconds_shown = cd_run ? cd_secs : 4'd0;
    r.notify        = note;
    r.clean_buttons = db_level;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (n_err < 40)
      $display("mismatch at result %0d: %s got %0d want %0d", n_checked, what, got, want);
    n_err++;
  endtask

  // predict on every accepted input beat, check every accepted result beat
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) status_q.push_back(next_lock_status(in_buttons_n));
      if (out_valid && !out_stall) begin
        n_checked++;
        if (status_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", 1, 0);
        end else begin
          want = status_q.pop_front();
          if (out_is_armed !== want.is_armed)
            report_mismatch("is_armed", out_is_armed, want.is_armed);
          if (out_alarm_out !== want.alarm_out)
            report_mismatch("alarm_out", out_alarm_out, want.alarm_out);
          if (out_led_a !== want.led_a) report_mismatch("led_a", out_led_a, want.led_a);
          if (out_led_b !== want.led_b) report_mismatch("led_b", out_led_b, want.led_b);
          if (out_motor_start !== want.motor_start)
            report_mismatch("motor_start", out_motor_start, want.motor_start);
          if (out_motor_reverse !== want.motor_reverse)
            report_mismatch("motor_reverse", out_motor_reverse, want.motor_reverse);
          if (out_entry_count !== want.entry_count)
            report_mismatch("entry_count", out_entry_count, want.entry_count);
          if (out_seconds_shown !== want.seconds_shown)
            report_mismatch("seconds_shown", out_seconds_shown, want.seconds_shown);
          if (out_notify !== want.notify) report_mismatch("notify", out_notify, want.notify);
          if (out_clean_buttons !== want.clean_buttons)
            report_mismatch("clean_buttons", out_clean_buttons, want.clean_buttons);
          if (want.motor_start && !want.motor_reverse) n_arm_turns++;
          if (want.motor_start && want.motor_reverse) n_disarm_turns++;
          if (want.notify == NOTIFY_RAISED) n_alarms++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(1, 100) <= out_stall_pct);
  end

  task automatic send_tick(input logic [2:0] raw);
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_buttons_n <= raw;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write one register, then read it back
  task automatic lock_reg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] want;
    hold_until_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = '0;
    case (idx)
      REG_ARM_CODE: begin
        reg_arm = val[5:0];
        want[5:0] = val[5:0];
      end
      REG_DISARM_CODE: begin
        reg_disarm = val[5:0];
        want[5:0] = val[5:0];
      end
      REG_COUNTDOWN: begin
        reg_cd = val[3:0];
        if (!cd_run) cd_secs = val[3:0];
        want[3:0] = val[3:0];
      end
      REG_SECOND_LIM: begin
        reg_sec_lim = val[10:0];
        want[10:0] = val[10:0];
      end
      REG_BLINK_LIM: begin
        reg_blink_lim = val[10:0];
        want[10:0] = val[10:0];
      end
      default: ;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(3'b111);
  endtask

  task automatic press_raw(input logic [2:0] raw, input int hold, input int rel);
    repeat (hold) send_tick(raw);
    idle_ticks(rel);
  endtask

  task automatic press_key(input logic [1:0] btn);
    logic [2:0] raw;
    raw = ~(3'b001 << (btn - 2'd1));
    // contact bounce ahead of the steady press
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) send_tick($urandom_range(0, 1) ? raw : 3'b111);
    press_raw(raw, $urandom_range(8, 12), $urandom_range(8, 12));
  endtask

  task automatic key_in_code(input logic [5:0] code);
    int i;
    logic [1:0] d;
    for (i = 0; i < 3; i++) begin
      d = code[2*i +: 2];
      press_key(d == BUTTON_NONE ? BUTTON_1 : d);
    end
  endtask

  task automatic wait_countdown();
    while (cd_run) send_tick(3'b111);
    idle_ticks(3);
  endtask

  function automatic logic [5:0] random_code();
    logic [5:0] c;
    int i;
    for (i = 0; i < 3; i++)
      c[2*i +: 2] = ($urandom_range(0, 9) == 0) ? BUTTON_NONE : 2'($urandom_range(1, 3));
    return c;
  endfunction

  // ---------------- tests ----------------

  task automatic test_power_up_release();
    repeat (3) send_tick(3'b000);
    press_raw(3'b010, 9, 0);
    idle_ticks(10);
  endtask

  task automatic test_default_arm();
    // short seconds keep the countdown brief
    lock_reg_write(REG_SECOND_LIM, 32'd4);
    press_key(BUTTON_2);        // wrong first digit while disarmed
    key_in_code(reg_arm);
    press_key(BUTTON_1);        // press at entry position three
    key_in_code(reg_arm);       // code again while the countdown runs
    wait_countdown();
  endtask

  task automatic test_alarm_and_disarm();
    lock_reg_write(REG_BLINK_LIM, 32'd15);
    press_key(BUTTON_1);
    idle_ticks(20);
    hold_until_drained();
    idle_ticks(20);
    press_raw(3'b000, 9, 9);    // all buttons at once, button 1 wins
    press_raw(3'b011, 9, 9);
    key_in_code(reg_disarm);
    idle_ticks(10);
  endtask

  task automatic test_register_extremes();
    lock_reg_write(REG_ARM_CODE, 32'h3F);
    lock_reg_write(REG_DISARM_CODE, 32'h3F);
    lock_reg_write(REG_COUNTDOWN, 32'd0);
    lock_reg_write(REG_SECOND_LIM, 32'd0);
    lock_reg_write(REG_BLINK_LIM, 32'd0);
    key_in_code(reg_arm);
    wait_countdown();
    press_key(BUTTON_1);
    idle_ticks(10);
    key_in_code(reg_disarm);

    lock_reg_write(REG_COUNTDOWN, 32'd15);
    key_in_code(reg_arm);
    wait_countdown();
    key_in_code(reg_disarm);

    lock_reg_write(REG_COUNTDOWN, 32'd1);
    lock_reg_write(REG_SECOND_LIM, 32'd2047);
    lock_reg_write(REG_BLINK_LIM, 32'd2047);

    // zero digits can never match a pressed button
    lock_reg_write(REG_ARM_CODE, 32'd0);
    lock_reg_write(REG_DISARM_CODE, 32'd0);
    press_key(BUTTON_1);
    press_key(BUTTON_3);
    lock_reg_write(REG_ARM_CODE, 32'h39);
    lock_reg_write(REG_SECOND_LIM, 32'd3);
    lock_reg_write(REG_BLINK_LIM, 32'd1024);
    key_in_code(reg_arm);
    wait_countdown();
    press_key(BUTTON_2);
    lock_reg_write(REG_DISARM_CODE, 32'h2A);
    key_in_code(reg_disarm);
  endtask

  task automatic run_traffic_phase(input int send_pct, input int stall_pct, input int quota);
    int stop_at;
    int pick;
    lock_reg_write(REG_ARM_CODE, random_code());
    lock_reg_write(REG_DISARM_CODE, random_code());
    lock_reg_write(REG_COUNTDOWN, ($urandom_range(0, 7) == 0) ? 15 : $urandom_range(0, 4));
    lock_reg_write(REG_SECOND_LIM, $urandom_range(0, 7));
    lock_reg_write(REG_BLINK_LIM, $urandom_range(0, 31));
    send_idle_pct = send_pct;
    out_stall_pct = stall_pct;
    stop_at = n_sent + quota;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(3, 20)) send_tick(3'($urandom_range(0, 7)));
      end else if (pick < 20) begin
        press_raw(3'($urandom_range(0, 6)), $urandom_range(1, 12), $urandom_range(8, 12));
      end else if (pick < 24) begin
        hold_until_drained();
      end else if (lock_armed) begin
        if ($urandom_range(0, 2) == 0) begin
          press_key(reg_disarm[1:0] == BUTTON_3 ? BUTTON_1 : reg_disarm[1:0] + 2'd1);
          idle_ticks($urandom_range(0, 30));
        end
        key_in_code(reg_disarm);
      end else begin
        key_in_code(reg_arm);
        if (cd_run && $urandom_range(0, 3) == 0) press_key(2'($urandom_range(1, 3)));
        wait_countdown();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 60);
    run_traffic_phase(85, 0, 50);
    run_traffic_phase(0, 85, 50);
    run_traffic_phase(30, 30, 60);
    send_idle_pct = 0;
    out_stall_pct = 0;
  endtask

  initial begin
    int wait_cycles;
    foreach (db_hist[i]) db_hist[i] = 3'b000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_up_release();
    test_default_arm();
    test_alarm_and_disarm();
    test_register_extremes();
    test_random_traffic();

    in_valid <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (status_q.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (status_q.size() != 0) report_mismatch("results never delivered", 0, status_q.size());

    $display("covered %0d ticks, %0d results checked, default, extreme and random settings",
             n_sent, n_checked);
    $display("arm turns %0d, disarm turns %0d, alarms raised %0d, mismatches %0d",
             n_arm_turns, n_disarm_turns, n_alarms, n_err);
    if (n_err == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("run did not complete in time");
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/kadc_pkg.sv
rtl/kadc_cfg.sv
rtl/kadc_debounce.sv
rtl/kadc_core.sv
rtl/keypad_arm_disarm_controller.sv
bench/tb_top.sv
